// ===== sv/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// shared widths, constants, arctangent table and pipeline types for the
// quaternion to euler angle converter
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_ITERATIONS_DEF   = 16;
    localparam int ANGLE_FRACTION_BITS_DEF = 13;

    localparam int Q_W         = 16;
    localparam int P_W         = 18;
    localparam int PROD_W      = 2 * P_W;
    localparam int XY_W        = 42;
    localparam int Z_W         = 35;
    localparam int A_W         = 32;
    localparam int RAD_W       = 61;
    localparam int ROOT_W      = 31;
    localparam int ISQRT_W     = 62;
    localparam int ISQRT_STEPS = 31;
    localparam int THR_W       = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int ANGLE_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TILT = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0] GATE_RESET = THR_W'(819);
    localparam logic [THR_W-1:0] TILT_RESET = THR_W'(164);

    localparam logic signed [Z_W-1:0] PI30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI30 = 35'sd1686629713;

    localparam logic signed [Z_W-1:0] ATAN_TAB [32] = '{
        35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
        35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
        35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
        35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
        35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
        35'sd1024,      35'sd512,       35'sd256,       35'sd128,
        35'sd64,        35'sd32,        35'sd16,        35'sd8,
        35'sd4,         35'sd2,         35'sd1,         35'sd0
    };

    typedef enum logic [1:0] {
        BR_MIRROR = 2'd0,
        BR_PLAIN  = 2'd1,
        BR_PINNED = 2'd2
    } branch_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   done;
    } cordic_state_t;

    typedef struct packed {
        logic [ISQRT_W-1:0] rem;
        logic [ISQRT_W-1:0] root;
    } isqrt_state_t;

    typedef struct packed {
        logic    gate_ok;
        branch_t branch;
        logic    a_pos;
    } side_t;

endpackage

// ===== sv/qte_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// qte_cordic_cell
// one vectoring micro-rotation of the arctangent chain, registered
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                  aclk,
    input  logic                  en,
    input  qte_pkg::cordic_state_t st_in,
    output qte_pkg::cordic_state_t st_out
);
    import qte_pkg::*;

    cordic_state_t          st_next;
    cordic_state_t          st_reg;
    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    always_comb begin
        x_in    = st_in.x;
        y_in    = st_in.y;
        z_in    = st_in.z;
        xs      = x_in >>> STAGE;
        ys      = y_in >>> STAGE;
        st_next = st_in;
        if (!st_in.done) begin
            if (!y_in[XY_W-1]) begin
                st_next.x = x_in + ys;
                st_next.y = y_in - xs;
                st_next.z = z_in + ATAN_TAB[STAGE];
            end else begin
                st_next.x = x_in - ys;
                st_next.y = y_in + xs;
                st_next.z = z_in - ATAN_TAB[STAGE];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

// ===== sv/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// pipelined atan2: quadrant and axis handling, a row of rotation cells,
// then clamping to plus or minus pi
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int ITERATIONS = qte_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [qte_pkg::XY_W-1:0]    in_x,
    input  logic signed [qte_pkg::XY_W-1:0]    in_y,
    output logic signed [qte_pkg::Z_W-1:0]     out_z
);
    import qte_pkg::*;

    cordic_state_t         prep_next;
    cordic_state_t         prep_reg;
    cordic_state_t         chain [ITERATIONS+1];
    logic signed [Z_W-1:0] last_z;
    logic signed [Z_W-1:0] z_next;
    logic signed [Z_W-1:0] z_reg;

    always_comb begin
        prep_next.x    = in_x;
        prep_next.y    = in_y;
        prep_next.z    = '0;
        prep_next.done = 1'b0;
        if (in_y == '0) begin
            prep_next.done = 1'b1;
            prep_next.z    = in_x[XY_W-1] ? PI30 : '0;
        end else if (in_x == '0) begin
            prep_next.done = 1'b1;
            prep_next.z    = in_y[XY_W-1] ? -HALF_PI30 : HALF_PI30;
        end else if (in_x[XY_W-1]) begin
            prep_next.x = -in_x;
            prep_next.y = -in_y;
            prep_next.z = in_y[XY_W-1] ? -PI30 : PI30;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign chain[0] = prep_reg;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        qte_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .aclk   (aclk),
            .en     (en),
            .st_in  (chain[g]),
            .st_out (chain[g+1])
        );
    end

    always_comb begin
        last_z = chain[ITERATIONS].z;
        if (last_z > PI30) begin
            z_next = PI30;
        end else if (last_z < -PI30) begin
            z_next = -PI30;
        end else begin
            z_next = last_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg <= z_next;
        end
    end

    assign out_z = z_reg;

endmodule

// ===== sv/qte_isqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qte_isqrt_cell
// one result bit of the integer square root, registered
// ----------------------------------------------------------------------------
module qte_isqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  qte_pkg::isqrt_state_t st_in,
    output qte_pkg::isqrt_state_t st_out
);
    import qte_pkg::*;

    localparam logic [ISQRT_W-1:0] BIT = ISQRT_W'(1) << (2 * (ISQRT_STEPS - 1 - STEP));

    isqrt_state_t       st_next;
    isqrt_state_t       st_reg;
    logic [ISQRT_W-1:0] trial;

    always_comb begin
        trial = st_in.root + BIT;
        if (st_in.rem >= trial) begin
            st_next.rem  = st_in.rem - trial;
            st_next.root = (st_in.root >> 1) + BIT;
        end else begin
            st_next.rem  = st_in.rem;
            st_next.root = st_in.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

// ===== sv/qte_isqrt.sv =====
// ----------------------------------------------------------------------------
// qte_isqrt
// pipelined integer square root, one cell per result bit
// ----------------------------------------------------------------------------
module qte_isqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [qte_pkg::RAD_W-1:0]     rad,
    output logic [qte_pkg::ROOT_W-1:0]    root
);
    import qte_pkg::*;

    isqrt_state_t chain [ISQRT_STEPS+1];

    assign chain[0].rem  = ISQRT_W'(rad);
    assign chain[0].root = '0;

    for (genvar g = 0; g < ISQRT_STEPS; g++) begin : g_cell
        qte_isqrt_cell #(
            .STEP (g)
        ) u_cell (
            .aclk   (aclk),
            .en     (en),
            .st_in  (chain[g]),
            .st_out (chain[g+1])
        );
    end

    assign root = chain[ISQRT_STEPS].root[ROOT_W-1:0];

endmodule

// ===== sv/quaternion_to_euler_angles_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// throughput: one request per cycle; a stalled result holds the whole pipe
// the longest path is the isqrt cell row feeding the pitch arctangent cell row
// reset: clears the valid line and output valid, thresholds return to 819 and 164
// converts a Q2.14 quaternion to roll, pitch and yaw in radians
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core #(
    parameter int CORDIC_ITERATIONS   = qte_pkg::CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_FRACTION_BITS = qte_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qte_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qte_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [qte_pkg::Q_W-1:0]       s_quat_x,
    input  logic signed [qte_pkg::Q_W-1:0]       s_quat_y,
    input  logic signed [qte_pkg::Q_W-1:0]       s_quat_z,
    input  logic signed [qte_pkg::Q_W-1:0]       s_quat_w,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [qte_pkg::ANGLE_W-1:0]   m_roll_angle,
    output logic signed [qte_pkg::ANGLE_W-1:0]   m_pitch_angle,
    output logic signed [qte_pkg::ANGLE_W-1:0]   m_yaw_angle,
    output logic [1:0]                           m_branch_taken,
    output logic                                 m_valid_res
);
    import qte_pkg::*;

    localparam int SH    = 30 - ANGLE_FRACTION_BITS;
    localparam int RD    = ISQRT_STEPS + 1;
    localparam int SD    = ISQRT_STEPS + CORDIC_ITERATIONS + 3;
    localparam int VLEN  = ISQRT_STEPS + CORDIC_ITERATIONS + 6;
    localparam int D_W   = P_W + 2;
    localparam int AR_W  = PROD_W + 4;

    localparam logic signed [Z_W-1:0]     RND    = Z_W'(1) << (SH - 1);
    localparam logic signed [Z_W-1:0]     SAT_HI = Z_W'((1 << (ANGLE_W - 1)) - 1);
    localparam logic signed [Z_W-1:0]     SAT_LO = -SAT_HI - Z_W'(1);
    localparam logic signed [AR_W-1:0]    ONE30  = AR_W'(1) << 30;
    localparam logic [RAD_W-1:0]          ONE60  = RAD_W'(1) << (RAD_W - 1);

    function automatic logic signed [ANGLE_W-1:0] to_out(input logic signed [Z_W-1:0] zv);
        logic signed [Z_W-1:0] r;
        r = (zv + RND) >>> SH;
        if (r > SAT_HI) begin
            return SAT_HI[ANGLE_W-1:0];
        end else if (r < SAT_LO) begin
            return SAT_LO[ANGLE_W-1:0];
        end
        return r[ANGLE_W-1:0];
    endfunction

    // control
    logic              en;
    logic              ld0;
    logic [VLEN-1:0]   v_reg;
    logic [THR_W-1:0]  gate_reg;
    logic [THR_W-1:0]  tilt_reg;

    // stage 1
    logic signed [P_W-1:0] qx, qy, qz, qw;
    logic signed [P_W-1:0] p0_next, p1_next, p2_next, p3_next;
    logic signed [P_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;

    // stage 2
    logic signed [D_W-1:0]    ap0, ap1, ap2, ap3;
    logic signed [D_W-1:0]    gate2, tilt2;
    logic                     gate_next, gate_ok_reg;
    branch_t                  br_next, br_reg;
    logic signed [PROD_W-1:0] pp00_reg, pp11_reg, pp22_reg, pp33_reg;
    logic signed [PROD_W-1:0] pp01_reg, pp23_reg, pp03_reg, pp12_reg;
    logic signed [PROD_W-1:0] pp02_reg, pp13_reg;

    // stage 3
    logic signed [AR_W-1:0]  a_raw;
    logic signed [AR_W-1:0]  a_clip;
    logic signed [XY_W-1:0]  roll_y_reg, roll_x_reg, yaw_y_reg, yaw_x_reg;
    logic signed [A_W-1:0]   a3_reg;
    side_t                   side3_reg;

    // stage 4
    logic [A_W-2:0]          a_mag;
    logic [2*A_W-3:0]        a_sq;
    logic [RAD_W-1:0]        rad_reg;
    logic signed [A_W-1:0]   a4_reg;

    // long paths
    logic [ROOT_W-1:0]       root;
    logic signed [A_W-1:0]   a_dly_reg [ISQRT_STEPS];
    logic signed [Z_W-1:0]   roll_z, yaw_z, pitch_z;
    logic signed [ANGLE_W-1:0] roll_q, yaw_q;
    logic signed [ANGLE_W-1:0] roll_dly_reg [RD];
    logic signed [ANGLE_W-1:0] yaw_dly_reg [RD];
    side_t                   side_dly_reg [SD];

    // output
    side_t                   sd;
    logic signed [Z_W-1:0]   pitch_adj;
    logic                    m_valid_reg;
    logic signed [ANGLE_W-1:0] roll_out_reg, pitch_out_reg, yaw_out_reg;
    logic [1:0]              br_out_reg;
    logic                    res_out_reg;

    assign en        = !m_valid_reg || m_ready;
    assign ld0       = en || !v_reg[0];
    assign s_ready   = ld0;
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg <= GATE_RESET;
            tilt_reg <= TILT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_GATE) begin
                gate_reg <= cfg_data[THR_W-1:0];
            end else if (cfg_index == CFG_TILT) begin
                tilt_reg <= cfg_data[THR_W-1:0];
            end
        end
    end

    // valid line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ld0) begin
                v_reg[0] <= s_valid;
            end
            if (en) begin
                v_reg[VLEN-1:1] <= v_reg[VLEN-2:0];
                m_valid_reg     <= v_reg[VLEN-1];
            end
        end
    end

    // frame rotation
    always_comb begin
        qx      = P_W'(s_quat_x);
        qy      = P_W'(s_quat_y);
        qz      = P_W'(s_quat_z);
        qw      = P_W'(s_quat_w);
        p0_next = qy + qz + qw - qx;
        p1_next = qz - qy - qx - qw;
        p2_next = qx - qw + qy + qz;
        p3_next = qz - qy + qx + qw;
    end

    always_ff @(posedge aclk) begin
        if (ld0) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
    end

    // products and threshold tests
    always_comb begin
        ap0   = p0_reg[P_W-1] ? -D_W'(p0_reg) : D_W'(p0_reg);
        ap1   = p1_reg[P_W-1] ? -D_W'(p1_reg) : D_W'(p1_reg);
        ap2   = p2_reg[P_W-1] ? -D_W'(p2_reg) : D_W'(p2_reg);
        ap3   = p3_reg[P_W-1] ? -D_W'(p3_reg) : D_W'(p3_reg);
        gate2 = D_W'($signed({1'b0, gate_reg, 1'b0}));
        tilt2 = D_W'($signed({1'b0, tilt_reg, 1'b0}));
        gate_next = (ap0 - ap2) < gate2;
        if ((ap3 - ap1) > tilt2) begin
            br_next = BR_MIRROR;
        end else if ((ap1 - ap3) > tilt2) begin
            br_next = BR_PLAIN;
        end else begin
            br_next = BR_PINNED;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gate_ok_reg <= gate_next;
            br_reg      <= br_next;
            pp00_reg    <= p0_reg * p0_reg;
            pp11_reg    <= p1_reg * p1_reg;
            pp22_reg    <= p2_reg * p2_reg;
            pp33_reg    <= p3_reg * p3_reg;
            pp01_reg    <= p0_reg * p1_reg;
            pp23_reg    <= p2_reg * p3_reg;
            pp03_reg    <= p0_reg * p3_reg;
            pp12_reg    <= p1_reg * p2_reg;
            pp02_reg    <= p0_reg * p2_reg;
            pp13_reg    <= p1_reg * p3_reg;
        end
    end

    // atan2 arguments and clamped asin argument
    always_comb begin
        a_raw = (AR_W'(pp02_reg) + AR_W'(pp13_reg)) <<< 1;
        if (a_raw > ONE30) begin
            a_clip = ONE30;
        end else if (a_raw < -ONE30) begin
            a_clip = -ONE30;
        end else begin
            a_clip = a_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_y_reg <= (XY_W'(pp01_reg) - XY_W'(pp23_reg)) <<< 1;
            roll_x_reg <= XY_W'(pp00_reg) - XY_W'(pp11_reg) - XY_W'(pp22_reg)
                          + XY_W'(pp33_reg);
            yaw_y_reg  <= (XY_W'(pp03_reg) - XY_W'(pp12_reg)) <<< 1;
            yaw_x_reg  <= XY_W'(pp00_reg) + XY_W'(pp11_reg) - XY_W'(pp22_reg)
                          - XY_W'(pp33_reg);
            a3_reg            <= a_clip[A_W-1:0];
            side3_reg.gate_ok <= gate_ok_reg;
            side3_reg.branch  <= br_reg;
            side3_reg.a_pos   <= !a_raw[AR_W-1] && (a_raw != '0);
        end
    end

    // radicand 1 - a*a
    assign a_mag = a3_reg[A_W-1] ? (A_W-1)'(-a3_reg) : (A_W-1)'(a3_reg);
    assign a_sq  = a_mag * a_mag;

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg <= ONE60 - RAD_W'(a_sq);
            a4_reg  <= a3_reg;
        end
    end

    qte_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (rad_reg),
        .root (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            a_dly_reg[0] <= a4_reg;
            for (int k = 1; k < ISQRT_STEPS; k++) begin
                a_dly_reg[k] <= a_dly_reg[k-1];
            end
        end
    end

    qte_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_roll (
        .aclk  (aclk),
        .en    (en),
        .in_x  (roll_x_reg),
        .in_y  (roll_y_reg),
        .out_z (roll_z)
    );

    qte_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_yaw (
        .aclk  (aclk),
        .en    (en),
        .in_x  (yaw_x_reg),
        .in_y  (yaw_y_reg),
        .out_z (yaw_z)
    );

    qte_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_pitch (
        .aclk  (aclk),
        .en    (en),
        .in_x  ($signed(XY_W'(root))),
        .in_y  (XY_W'(a_dly_reg[ISQRT_STEPS-1])),
        .out_z (pitch_z)
    );

    assign roll_q = to_out(roll_z);
    assign yaw_q  = to_out(yaw_z);

    // align roll, yaw and sideband with pitch
    always_ff @(posedge aclk) begin
        if (en) begin
            roll_dly_reg[0] <= roll_q;
            yaw_dly_reg[0]  <= yaw_q;
            for (int k = 1; k < RD; k++) begin
                roll_dly_reg[k] <= roll_dly_reg[k-1];
                yaw_dly_reg[k]  <= yaw_dly_reg[k-1];
            end
            side_dly_reg[0] <= side3_reg;
            for (int k = 1; k < SD; k++) begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    // pitch branch adjustment
    always_comb begin
        sd = side_dly_reg[SD-1];
        unique case (sd.branch)
            BR_MIRROR: pitch_adj = sd.a_pos ? (PI30 - pitch_z) : (-PI30 - pitch_z);
            BR_PINNED: pitch_adj = sd.a_pos ? HALF_PI30 : -HALF_PI30;
            default:   pitch_adj = pitch_z;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sd.gate_ok) begin
                roll_out_reg  <= roll_dly_reg[RD-1];
                pitch_out_reg <= to_out(pitch_adj);
                yaw_out_reg   <= yaw_dly_reg[RD-1];
                br_out_reg    <= sd.branch;
                res_out_reg   <= 1'b1;
            end else begin
                roll_out_reg  <= '0;
                pitch_out_reg <= '0;
                yaw_out_reg   <= '0;
                br_out_reg    <= BR_MIRROR;
                res_out_reg   <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_roll_angle   = roll_out_reg;
    assign m_pitch_angle  = pitch_out_reg;
    assign m_yaw_angle    = yaw_out_reg;
    assign m_branch_taken = br_out_reg;
    assign m_valid_res    = res_out_reg;

    // checks
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_roll_angle == '0 && m_pitch_angle == '0
            && m_yaw_angle == '0 && m_branch_taken == BR_MIRROR)
        else $error("rejected request carries nonzero fields");

    a_branch_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_branch_taken == BR_MIRROR || m_branch_taken == BR_PLAIN
            || m_branch_taken == BR_PINNED)
        else $error("unused branch code on output");

    a_stall_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && v_reg[0])
        else $error("input held off without an output stall");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pitch_angle)
            && $stable(v_reg[VLEN-1:1]))
        else $error("pipeline moved during output stall");

endmodule
